// ===== rtl/bsmh_pkg.sv =====
package bsmh_pkg;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT,
        ST_DP,
        ST_PICK,
        ST_EMIT
    } state_t;

    // Sorted box as held in one cell.
    typedef struct packed {
        logic [15:0] largest;
        logic [15:0] middle;
        logic [15:0] small_side;
        logic [6:0]  arrival;
        logic [31:0] area;
        logic        valid;
    } box_t;

endpackage

// ===== rtl/bsmh_if.sv =====
interface bsmh_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] dim_a;
    logic [15:0] dim_b;
    logic [15:0] dim_c;
    logic        is_last;

    modport source (output valid, dim_a, dim_b, dim_c, is_last, input ready);
    modport sink (input valid, dim_a, dim_b, dim_c, is_last, output ready);
endinterface

interface bsmh_out_if;
    logic        valid;
    logic        ready;
    logic [21:0] total_height;
    logic [6:0]  chain_count;
    logic [6:0]  box_number;
    logic [15:0] middle_side;
    logic [15:0] largest_side;
    logic [15:0] smallest_side;
    logic        last_of_run;

    modport source (output valid, total_height, chain_count, box_number, middle_side,
                    largest_side, smallest_side, last_of_run, input ready);
    modport sink (input valid, total_height, chain_count, box_number, middle_side,
                  largest_side, smallest_side, last_of_run, output ready);
endinterface

// ===== rtl/bsmh_cell.sv =====
// One slot of the insertion-sort chain. A new box enters at the left; each
// cell keeps the box that sorts first and passes the other to its right
// neighbor. Boxes order by area, then by arrival, so ties keep arrival order.
module bsmh_cell
    import bsmh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic clear,
    input  box_t box_in,
    output box_t box_out,
    output box_t held
);

    box_t held_reg;
    box_t held_next;
    box_t pass_reg;
    box_t pass_next;

    always_comb
    begin
        held_next = held_reg;
        pass_next = box_in;
        if (clear)
        begin
            held_next.valid = 1'b0;
            pass_next.valid = 1'b0;
        end
        else if (box_in.valid)
        begin
            if (!held_reg.valid)
            begin
                held_next = box_in;
                pass_next.valid = 1'b0;
            end
            else if (box_in.area < held_reg.area
                     || (box_in.area == held_reg.area
                         && box_in.arrival < held_reg.arrival))
            begin
                held_next = box_in;
                pass_next = held_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg.valid <= 1'b0;
            pass_reg.valid <= 1'b0;
        end
        else
        begin
            held_reg <= held_next;
            pass_reg <= pass_next;
        end
    end

    // payload bits need no reset
    assign box_out = pass_reg;
    assign held    = held_reg;

endmodule

// ===== rtl/bsmh_dp_cell.sv =====
// DP slot for one sorted box: compares against a candidate box j broadcast
// each cycle and keeps the strictly tallest chain ending here.
module bsmh_dp_cell
    import bsmh_pkg::*;
#(
    parameter int IDX_BITS = 6
)
(
    input  logic                clk,
    input  logic                start,
    input  logic                active,
    input  box_t                me,
    input  logic [IDX_BITS-1:0] j_idx,
    input  logic [15:0]         j_large,
    input  logic [15:0]         j_middle,
    input  logic [21:0]         j_height,
    input  logic [6:0]          j_len,
    output logic [21:0]         height,
    output logic [IDX_BITS-1:0] link,
    output logic [6:0]          len
);

    logic [21:0]         height_reg, height_next;
    logic [IDX_BITS-1:0] link_reg, link_next;
    logic [6:0]          len_reg, len_next;
    logic [21:0]         cand;

    assign cand = j_height + 22'(me.small_side);

    always_comb
    begin
        height_next = height_reg;
        link_next   = link_reg;
        len_next    = len_reg;
        if (start)
        begin
            height_next = 22'(me.small_side);
            link_next   = '0;
            len_next    = (me.small_side != 16'd0) ? 7'd1 : 7'd0;
        end
        else if (active && me.largest >= j_large && me.middle >= j_middle
                 && cand > height_reg)
        begin
            height_next = cand;
            link_next   = j_idx;
            len_next    = j_len + 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        height_reg <= height_next;
        link_reg   <= link_next;
        len_reg    <= len_next;
    end

    assign height = height_reg;
    assign link   = link_reg;
    assign len    = len_reg;

endmodule

// ===== rtl/box_stack_max_height_top.sv =====
// Tallest box stack.
// in: one box per request (dim_a, dim_b, dim_c, is_last); boxes load into a
//   chain of sort cells at one per cycle. Up to MAX_BOXES boxes are kept,
//   further ones are dropped but an is_last mark still starts the run.
// After is_last the block takes no request while it works: it flushes the sort
//   chain in ST_SORT, runs the DP in ST_DP (j walks 0..count-1, every cell
//   i>j updates in parallel) and picks the top in ST_PICK. The first result
//   then appears on out, followed by one result per cycle from the top of the
//   stack down while the receiver takes them.
// Results carry total_height and chain_count; last_of_run marks the bottom.
// If the receiver stalls, the current result holds until taken, and in
//   stays blocked. Loading resumes the cycle after the last result is taken
//   (if no stack has height above zero, it passes an idle ST_EMIT instead).
// Reset empties the sort chain and returns to loading; box storage holds
//   no reset value.
module box_stack_max_height_top
    import bsmh_pkg::*;
#(
    parameter int MAX_BOXES = 64,
    parameter int SIDE_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    bsmh_in_if.sink    in_ch,
    bsmh_out_if.source out_ch
);

    localparam int IB = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam logic [15:0] SMASK = 16'((17'd1 << ((SIDE_BITS > 16) ? 16 : SIDE_BITS)) - 17'd1);

    state_t state_reg, state_next;
    logic [6:0]    count_reg, count_next;
    logic [6:0]    step_reg, step_next;
    logic [IB-1:0] k_reg, k_next;
    logic [21:0]   best_reg, best_next;
    logic [IB-1:0] top_reg, top_next;
    logic [6:0]    len_reg, len_next;
    logic [6:0]    left_reg, left_next;

    box_t chain_in [MAX_BOXES+1];
    box_t held [MAX_BOXES];
    logic [21:0]   h [MAX_BOXES];
    logic [IB-1:0] lk [MAX_BOXES];
    logic [6:0]    ln [MAX_BOXES];

    logic [15:0] s0, s1, s2, a1, b1, b2;
    logic        take, clear, dp_start;
    logic [IB-1:0] jj;

    always_comb
    begin
        s0 = in_ch.dim_a & SMASK;
        s1 = in_ch.dim_b & SMASK;
        s2 = in_ch.dim_c & SMASK;
        a1 = (s0 < s1) ? s1 : s0;
        b1 = (s0 < s1) ? s0 : s1;
        b2 = (b1 < s2) ? s2 : b1;
        chain_in[0].small_side = (b1 < s2) ? b1 : s2;
        chain_in[0].largest = (a1 < b2) ? b2 : a1;
        chain_in[0].middle  = (a1 < b2) ? a1 : b2;
        chain_in[0].arrival = count_reg + 7'd1;
        chain_in[0].area = 32'(chain_in[0].largest) * 32'(chain_in[0].middle);
        chain_in[0].valid = take && (count_reg < 7'(MAX_BOXES));
    end

    assign in_ch.ready = (state_reg == ST_LOAD);
    assign take  = in_ch.valid && in_ch.ready;
    assign clear = (state_reg == ST_EMIT) && (state_next == ST_LOAD);
    assign dp_start = (state_reg == ST_SORT) && (state_next == ST_DP);
    assign jj = step_reg[IB-1:0];

    genvar g;
    generate
        for (g = 0; g < MAX_BOXES; g++)
        begin : g_cell
            bsmh_cell u_cell (
                .clk(clk), .rst_n(rst_n), .clear(clear),
                .box_in(chain_in[g]), .box_out(chain_in[g+1]), .held(held[g])
            );
            bsmh_dp_cell #(.IDX_BITS(IB)) u_dp (
                .clk(clk), .start(dp_start),
                .active(state_reg == ST_DP && 7'(g) > step_reg && held[g].valid),
                .me(held[g]), .j_idx(jj),
                .j_large(held[jj].largest), .j_middle(held[jj].middle),
                .j_height(h[jj]), .j_len(ln[jj]),
                .height(h[g]), .link(lk[g]), .len(ln[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        step_next  = step_reg;
        k_next     = k_reg;
        best_next  = best_reg;
        top_next   = top_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (take)
                begin
                    if (count_reg < 7'(MAX_BOXES))
                        count_next = count_reg + 7'd1;
                    if (in_ch.is_last)
                    begin
                        state_next = ST_SORT;
                        step_next  = '0;
                    end
                end
            end
            ST_SORT:
            begin
                step_next = step_reg + 7'd1;
                if (step_reg == 7'(MAX_BOXES))
                begin
                    state_next = ST_DP;
                    step_next  = '0;
                end
            end
            ST_DP:
            begin
                step_next = step_reg + 7'd1;
                if (step_reg + 7'd1 >= count_reg)
                begin
                    state_next = ST_PICK;
                    step_next  = '0;
                    best_next  = '0;
                end
            end
            ST_PICK:
            begin
                if (step_reg < count_reg && h[jj] > best_reg)
                begin
                    best_next = h[jj];
                    top_next  = jj;
                end
                step_next = step_reg + 7'd1;
                if (step_reg + 7'd1 >= count_reg)
                begin
                    if (best_next == 22'd0)
                    begin
                        state_next = ST_EMIT;
                        left_next  = '0;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                        k_next     = top_next;
                        len_next   = ln[top_next];
                        left_next  = ln[top_next];
                    end
                end
            end
            ST_EMIT:
            begin
                if (left_reg == 7'd0)
                begin
                    state_next = ST_LOAD;
                    count_next = '0;
                end
                else if (out_ch.ready)
                begin
                    left_next = left_reg - 7'd1;
                    k_next    = lk[k_reg];
                    if (left_reg == 7'd1)
                    begin
                        state_next = ST_LOAD;
                        count_next = '0;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            step_reg  <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        best_reg <= best_next;
        top_reg  <= top_next;
        len_reg  <= len_next;
    end

    assign out_ch.valid         = (state_reg == ST_EMIT) && (left_reg != 7'd0);
    assign out_ch.total_height  = best_reg;
    assign out_ch.chain_count   = len_reg;
    assign out_ch.box_number    = held[k_reg].arrival;
    assign out_ch.middle_side   = held[k_reg].middle;
    assign out_ch.largest_side  = held[k_reg].largest;
    assign out_ch.smallest_side = held[k_reg].small_side;
    assign out_ch.last_of_run   = (left_reg == 7'd1);

endmodule
